>>> src/bnl_pkg.sv
// ----------------------------------------------------------------------------
// bnl_pkg: shared types and constants of the backoff notify limiter
// Field widths, status and register codes, and the structs that pass
// configuration, check items, state and results between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bnl_pkg;

  localparam int unsigned TIME_WIDTH  = 48;
  localparam int unsigned COUNT_WIDTH = 8;
  localparam int unsigned HOUR_WIDTH  = 5;
  localparam int unsigned CAP_WIDTH   = 8;
  localparam int unsigned DATA_WIDTH  = 64;
  localparam int unsigned ADDR_WIDTH  = 6;
  localparam int unsigned IDX_WIDTH   = 3;

  localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [TIME_WIDTH-1:0] START_INTERVAL_RST   = TIME_WIDTH'(1000);
  localparam logic [CAP_WIDTH-1:0]  MAX_PER_PERIOD_RST   = CAP_WIDTH'(8);
  localparam logic [HOUR_WIDTH-1:0] NIGHT_START_HOUR_RST = HOUR_WIDTH'(22);
  localparam logic [HOUR_WIDTH-1:0] NIGHT_END_HOUR_RST   = HOUR_WIDTH'(7);
  localparam logic [CAP_WIDTH-1:0]  MAX_NIGHT_RST        = CAP_WIDTH'(1);

  typedef enum logic [1:0] {
    ST_SENT       = 2'd0,
    ST_PERIOD_CAP = 2'd1,
    ST_NIGHT_CAP  = 2'd2,
    ST_NOT_DUE    = 2'd3
  } status_e;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_START_INTERVAL   = 3'd0,
    REG_MAX_PER_PERIOD   = 3'd1,
    REG_NIGHT_START_HOUR = 3'd2,
    REG_NIGHT_END_HOUR   = 3'd3,
    REG_MAX_NIGHT        = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] start_interval;
    logic [CAP_WIDTH-1:0]  max_per_period;
    logic [HOUR_WIDTH-1:0] night_start_hour;
    logic [HOUR_WIDTH-1:0] night_end_hour;
    logic [CAP_WIDTH-1:0]  max_night;
  } cfg_t;

  typedef struct packed {
    logic                  new_period;
    logic [TIME_WIDTH-1:0] now_ticks;
    logic [HOUR_WIDTH-1:0] hour_of_day;
  } item_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  interval_now;
    logic [TIME_WIDTH-1:0]  last_fire_time;
    logic [COUNT_WIDTH-1:0] period_count;
    logic [COUNT_WIDTH-1:0] night_count;
  } state_t;

  typedef struct packed {
    logic                  fire;
    status_e               status;
    logic [TIME_WIDTH-1:0] current_interval;
  } result_t;

endpackage

>>> src/bnl_decide.sv
// ----------------------------------------------------------------------------
// bnl_decide: per-check decision logic
// From the held check beat, the limiter state and the configuration, decide
// whether a notification fires and produce the next state and the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bnl_decide (
  input  bnl_pkg::cfg_t    cfg_i,
  input  bnl_pkg::item_t   item_i,
  input  bnl_pkg::state_t  state_i,
  output bnl_pkg::state_t  state_o,
  output bnl_pkg::result_t result_o
);
  import bnl_pkg::*;

  logic [TIME_WIDTH-1:0]  interval_base;
  logic [COUNT_WIDTH-1:0] period_base;
  logic [TIME_WIDTH-1:0]  since;
  logic [TIME_WIDTH-1:0]  interval_dbl;
  logic                   night;
  logic                   wraps;
  logic                   due;

  // Restart the backoff on a new period
  assign interval_base = item_i.new_period ? cfg_i.start_interval : state_i.interval_now;
  assign period_base   = item_i.new_period ? '0 : state_i.period_count;

  // Night window, wrapping past midnight when start is after end
  assign wraps = cfg_i.night_start_hour > cfg_i.night_end_hour;
  assign night = wraps
      ? ((item_i.hour_of_day >= cfg_i.night_start_hour) ||
         (item_i.hour_of_day <= cfg_i.night_end_hour))
      : ((item_i.hour_of_day >= cfg_i.night_start_hour) &&
         (item_i.hour_of_day <= cfg_i.night_end_hour));

  // Wrapping elapsed time and saturating doubling
  assign since        = item_i.now_ticks - state_i.last_fire_time;
  assign due          = (since >= interval_base) || item_i.new_period;
  assign interval_dbl = interval_base[TIME_WIDTH-1] ? TIME_MAX
                                                    : {interval_base[TIME_WIDTH-2:0], 1'b0};

  // Pick status and next state
  always_comb begin
    state_o              = state_i;
    state_o.interval_now = interval_base;
    state_o.period_count = period_base;
    result_o.status      = ST_NOT_DUE;
    if (COUNT_WIDTH'(cfg_i.max_per_period) <= period_base) begin
      result_o.status = ST_PERIOD_CAP;
    end else if (night && (COUNT_WIDTH'(cfg_i.max_night) <= state_i.night_count)) begin
      result_o.status = ST_NIGHT_CAP;
    end else begin
      if (!night) begin
        state_o.night_count = '0;
      end
      if (due) begin
        result_o.status        = ST_SENT;
        state_o.interval_now   = interval_dbl;
        state_o.last_fire_time = item_i.now_ticks;
        state_o.period_count   = (period_base == COUNT_MAX) ? COUNT_MAX
                                                            : period_base + 1'b1;
        if (night) begin
          state_o.night_count = (state_i.night_count == COUNT_MAX) ? COUNT_MAX
                                : state_i.night_count + 1'b1;
        end
      end
    end
    result_o.fire             = (result_o.status == ST_SENT);
    result_o.current_interval = state_o.interval_now;
  end

endmodule

>>> src/backoff_notify_limiter.sv
// ----------------------------------------------------------------------------
// backoff_notify_limiter: exponential backoff notify limiter with quiet hours
// An accepted check beat passes the input register, then the decision logic
// into the result register. Throughput: one check per cycle unless
// out_ready_i stalls the result register; the limiter state updates in the
// same cycle the held beat moves into the result register.
// Reset: asynchronous, active low; clears the pipeline valids, loads the
// register defaults and sets the interval to the default start interval.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module backoff_notify_limiter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bnl_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [bnl_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [bnl_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                               pready,
  // Check channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               new_period_i,
  input  logic [bnl_pkg::TIME_WIDTH-1:0]     now_ticks_i,
  input  logic [bnl_pkg::HOUR_WIDTH-1:0]     hour_of_day_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               fire_o,
  output logic [1:0]                         status_o,
  output logic [bnl_pkg::TIME_WIDTH-1:0]     current_interval_o
);
  import bnl_pkg::*;

  cfg_t     cfg_q;
  item_t    item_q;
  logic     item_valid_q;
  state_t   state_q;
  state_t   state_d;
  result_t  res_d;
  result_t  res_q;
  logic     out_valid_q;
  logic     advance;
  logic     load_in;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  // Configuration writes and reads
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_WIDTH-1:ADDR_WIDTH-IDX_WIDTH]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_interval   <= START_INTERVAL_RST;
      cfg_q.max_per_period   <= MAX_PER_PERIOD_RST;
      cfg_q.night_start_hour <= NIGHT_START_HOUR_RST;
      cfg_q.night_end_hour   <= NIGHT_END_HOUR_RST;
      cfg_q.max_night        <= MAX_NIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_INTERVAL:   cfg_q.start_interval   <= pwdata[TIME_WIDTH-1:0];
        REG_MAX_PER_PERIOD:   cfg_q.max_per_period   <= pwdata[CAP_WIDTH-1:0];
        REG_NIGHT_START_HOUR: cfg_q.night_start_hour <= pwdata[HOUR_WIDTH-1:0];
        REG_NIGHT_END_HOUR:   cfg_q.night_end_hour   <= pwdata[HOUR_WIDTH-1:0];
        REG_MAX_NIGHT:        cfg_q.max_night        <= pwdata[CAP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_START_INTERVAL:   prdata = DATA_WIDTH'(cfg_q.start_interval);
      REG_MAX_PER_PERIOD:   prdata = DATA_WIDTH'(cfg_q.max_per_period);
      REG_NIGHT_START_HOUR: prdata = DATA_WIDTH'(cfg_q.night_start_hour);
      REG_NIGHT_END_HOUR:   prdata = DATA_WIDTH'(cfg_q.night_end_hour);
      REG_MAX_NIGHT:        prdata = DATA_WIDTH'(cfg_q.max_night);
      default:              prdata = '0;
    endcase
  end

  // Pipeline flow: hold a beat while the result register is blocked
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign load_in    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      item_q.new_period  <= new_period_i;
      item_q.now_ticks   <= now_ticks_i;
      item_q.hour_of_day <= hour_of_day_i;
    end
  end

  bnl_decide u_decide (
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Limiter state advances with each beat that leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.interval_now   <= START_INTERVAL_RST;
      state_q.last_fire_time <= '0;
      state_q.period_count   <= '0;
      state_q.night_count    <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign fire_o             = res_q.fire;
  assign status_o           = res_q.status;
  assign current_interval_o = res_q.current_interval;

  // Fire flag agrees with the sent status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.fire == (res_q.status == ST_SENT)))
    else $error("fire flag disagrees with status");

  // Reported interval is the interval the state keeps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_q.current_interval == state_q.interval_now))
    else $error("reported interval differs from state");

  // A sent beat records its time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.status == ST_SENT)) |=>
      (state_q.last_fire_time == $past(item_q.now_ticks)))
    else $error("last fire time not recorded");

  // Suppressed beats without a new period leave the interval alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !item_q.new_period && (res_d.status != ST_SENT)) |=>
      (state_q.interval_now == $past(state_q.interval_now)))
    else $error("interval changed without firing");

  // No new result without a held beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!item_valid_q && !out_valid_q) |=> !out_valid_q)
    else $error("result appeared without a check");

endmodule
